// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  // Field widths
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 4;

  // Action codes (input tuser)
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One held entry
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic             enq;   // accepted enqueue, queue not full
    logic             deq;   // accepted dequeue, queue not empty
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
  input  wire logic           clk,
  input  wire spq_pkg::cmd_t  cmd,        // broadcast command
  input  wire logic           occ,        // this slot holds an entry
  input  wire logic           left_gt,    // left neighbor is empty or holds a larger priority
  input  wire spq_pkg::entry_t left_ent,  // left neighbor's entry
  input  wire spq_pkg::entry_t right_ent, // right neighbor's entry
  output spq_pkg::entry_t     ent,        // this cell's entry
  output logic                gt          // new item goes at or before this slot
);

  spq_pkg::entry_t ent_r;

  // Empty slots count as larger, so the new item lands at the end of the run
  assign gt  = !occ || (ent_r.pri > cmd.pri);
  assign ent = ent_r;

  // Insert / shift right on enqueue, shift left on dequeue
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (gt) begin
        if (left_gt) begin
          ent_r <= left_ent;
        end else begin
          ent_r.pri <= cmd.pri;
          ent_r.tag <= cmd.tag;
        end
      end
    end else if (cmd.deq) begin
      ent_r <= right_ent;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue, held in a chain of compare cells.
//
// Input channel (in_*): one item is an operation. in_tuser selects it:
// enqueue (priority in_tdata[7:0], tag in_tdata[23:8]) or dequeue.
// Output channel (out_*): exactly one result item per input item, carrying
// status, a valid flag for a returned entry, its priority and tag, and the
// entry count after the operation.
//
// Every cell compares its priority with the broadcast new priority and
// keeps its entry, loads the new item, takes its left neighbor's entry or
// takes its right neighbor's entry. The result is registered, so out_tvalid
// rises in the cycle after acceptance; throughput is one item per cycle
// while the receiver does not stall, set by the single output register.
//
// Reset clears the entry count and the output valid flag; the queue starts
// empty. While the receiver stalls, the result holds in the output register
// and in_tready is low until it is taken; in_tready follows out_tready
// combinationally when a result is waiting.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // priority_req[7:0], payload[23:8]
  input  wire logic [0:0]  in_tuser,   // action[0]
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_priority[7:0], out_payload[23:8],
                                       // fill_count[27:24], zero[31:28]
  output logic [2:0]       out_tuser   // status[1:0], out_valid[2]
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            full;
  logic            empty;
  logic            acc;
  spq_pkg::cmd_t   cmd;
  spq_pkg::entry_t ent [DEPTH];
  logic            gt  [DEPTH];

  logic [spq_pkg::STAT_W-1:0] stat;
  logic                       rvalid;
  logic [spq_pkg::PRI_W-1:0]  rpri;
  logic [spq_pkg::TAG_W-1:0]  rtag;
  logic [CW+3:0]              cnt_ext;

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  // Handshake
  assign in_tready = !out_tvalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign full      = (cnt_r >= CW'(DEPTH));
  assign empty     = (cnt_r == '0);

  // Command to the chain
  always_comb begin
    cmd.enq = acc && (in_tuser[0] == spq_pkg::ACT_ENQ) && !full;
    cmd.deq = acc && (in_tuser[0] == spq_pkg::ACT_DEQ) && !empty;
    cmd.pri = in_tdata[7:0];
    cmd.tag = in_tdata[23:8];
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            occ;
    logic            lgt;
    spq_pkg::entry_t lent;
    spq_pkg::entry_t rent;

    assign occ = (CW'(i) < cnt_r);

    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lent = ent[i];
    end else begin : g_mid
      assign lgt  = gt[i-1];
      assign lent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rent = ent[i];
    end else begin : g_body
      assign rent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .left_gt   (lgt),
      .left_ent  (lent),
      .right_ent (rent),
      .ent       (ent[i]),
      .gt        (gt[i])
    );
  end

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.enq) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.deq) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result fields
  always_comb begin
    stat   = spq_pkg::ST_DONE;
    rvalid = 1'b0;
    rpri   = '0;
    rtag   = '0;
    if (in_tuser[0] == spq_pkg::ACT_ENQ) begin
      if (full) begin
        stat = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      stat = spq_pkg::ST_EMPTY;
    end else begin
      rvalid = 1'b1;
      rpri   = ent[0].pri;
      rtag   = ent[0].tag;
    end
  end

  assign cnt_ext = {4'b0000, cnt_nxt};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (acc) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_tdata_r <= {4'b0000, cnt_ext[3:0], rtag, rpri};
      out_tuser_r <= {rvalid, stat};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
`default_nettype none

module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A returned entry always comes with a done status
  a_ret_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == spq_pkg::ST_DONE)
    else $error("returned entry with error status");

  // No entry returned means zero priority and tag
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[23:0] == 24'd0)
    else $error("nonzero entry fields without a returned entry");

  // An empty status comes with a zero entry count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == spq_pkg::ST_EMPTY |-> out_tdata[27:24] == 4'd0)
    else $error("empty status with nonzero count");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/tb_sorted_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

  localparam int unsigned QDEPTH   = 8;
  localparam int          N_DIR    = 22;
  localparam int          N_PHASE  = 633;

  // one result item, split into its fields
  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0] status;
    logic                       valid;
    logic [spq_pkg::PRI_W-1:0]  pri;
    logic [spq_pkg::TAG_W-1:0]  tag;
    logic [spq_pkg::FILL_W-1:0] fill;
  } spq_result_t;

  // directed row: operation plus an optional hand-written result
  typedef struct packed {
    logic                       act;
    logic [spq_pkg::PRI_W-1:0]  pri;
    logic [spq_pkg::TAG_W-1:0]  tag;
    logic                       typed;
    logic [spq_pkg::STAT_W-1:0] e_status;
    logic                       e_valid;
    logic [spq_pkg::PRI_W-1:0]  e_pri;
    logic [spq_pkg::TAG_W-1:0]  e_tag;
    logic [spq_pkg::FILL_W-1:0] e_fill;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b1, spq_pkg::ST_EMPTY, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd255, 16'hFFFF, 1'b1, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd1},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b1, spq_pkg::ST_DONE, 1'b1, 8'd255, 16'hFFFF, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd0,   16'h0000, 1'b1, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd1},
    '{spq_pkg::ACT_ENQ, 8'd128, 16'hA5A5, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd128, 16'h5A5A, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd255, 16'hFFFF, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd0,   16'h1234, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd64,  16'h0001, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd200, 16'h8000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd1,   16'h7FFF, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_ENQ, 8'd3,   16'hBEEF, 1'b1, spq_pkg::ST_FULL, 1'b0, 8'd0, 16'h0000, 4'd8},
    '{spq_pkg::ACT_ENQ, 8'd0,   16'hFFFF, 1'b1, spq_pkg::ST_FULL, 1'b0, 8'd0, 16'h0000, 4'd8},
    '{spq_pkg::ACT_DEQ, 8'd255, 16'hFFFF, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b0, spq_pkg::ST_DONE, 1'b0, 8'd0, 16'h0000, 4'd0},
    '{spq_pkg::ACT_DEQ, 8'd0,   16'h0000, 1'b1, spq_pkg::ST_EMPTY, 1'b0, 8'd0, 16'h0000, 4'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // priority_req[7:0], payload[23:8]
  logic [0:0]  in_tuser;   // action[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_priority[7:0], out_payload[23:8], fill_count[27:24]
  logic [2:0]  out_tuser;  // status[1:0], out_valid[2]

  // predictor state: sorted entries, front at index 0
  spq_pkg::entry_t held [QDEPTH];
  int unsigned     held_count;

  spq_result_t pending_results [$];
  int          errors;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          n_enq_ok, n_deq_ok, n_full, n_empty, max_fill;

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // apply one operation to the predicted queue and return its result
  function automatic spq_result_t queue_apply(logic act, logic [spq_pkg::PRI_W-1:0] pri,
                                              logic [spq_pkg::TAG_W-1:0] tag);
    spq_result_t r;
    int unsigned i;
    r = '0;
    if (act == spq_pkg::ACT_ENQ) begin
      if (held_count >= QDEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // shift larger priorities back; equal ones stay ahead
        i = held_count;
        while (i > 0 && held[i-1].pri > pri) begin
          held[i] = held[i-1];
          i--;
        end
        held[i].pri = pri;
        held[i].tag = tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.valid = 1'b1;
        r.pri   = held[0].pri;
        r.tag   = held[0].tag;
        for (i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
        held_count--;
      end
    end
    r.fill = held_count[spq_pkg::FILL_W-1:0];
    return r;
  endfunction

  // drive one item, wait for its handshake, then record its expected result
  task automatic send_op(input logic act, input logic [spq_pkg::PRI_W-1:0] pri,
                         input logic [spq_pkg::TAG_W-1:0] tag, input logic typed,
                         input spq_result_t typed_res);
    spq_result_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {tag, pri};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    pred = queue_apply(act, pri, tag);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result checker: sampled mid-cycle, where the handshake is settled
  spq_result_t got, want;
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[1:0];
      got.valid  = out_tuser[2];
      got.pri    = out_tdata[7:0];
      got.tag    = out_tdata[23:8];
      got.fill   = out_tdata[27:24];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.valid !== want.valid) begin
          errors++;
          $display("%0t: out_valid expected %0d got %0d", $time, want.valid, got.valid);
        end
        if (got.pri !== want.pri) begin
          errors++;
          $display("%0t: out_priority expected %0d got %0d", $time, want.pri, got.pri);
        end
        if (got.tag !== want.tag) begin
          errors++;
          $display("%0t: out_payload expected %h got %h", $time, want.tag, got.tag);
        end
        if (got.fill !== want.fill) begin
          errors++;
          $display("%0t: fill_count expected %0d got %0d", $time, want.fill, got.fill);
        end
      end
      case (got.status)
        spq_pkg::ST_FULL:  n_full++;
        spq_pkg::ST_EMPTY: n_empty++;
        default: begin
          if (got.valid) n_deq_ok++;
          else n_enq_ok++;
        end
      endcase
      if (got.fill > max_fill) max_fill = got.fill;
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    logic        act;
    logic [7:0]  pri;
    logic [15:0] tag;
    int          enq_pct;
    int          wait_cycles;
    spq_result_t row_res;

    errors      = 0;
    held_count  = 0;
    n_enq_ok    = 0;
    n_deq_ok    = 0;
    n_full      = 0;
    n_empty     = 0;
    max_fill    = 0;
    enq_pct     = 50;
    tx_idle_pct = 31;
    rx_idle_pct = 59;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and full rejects, extreme fields, ties in priority
    for (int r = 0; r < N_DIR; r++) begin
      row_res = '{DIR_TAB[r].e_status, DIR_TAB[r].e_valid, DIR_TAB[r].e_pri,
                  DIR_TAB[r].e_tag, DIR_TAB[r].e_fill};
      send_op(DIR_TAB[r].act, DIR_TAB[r].pri, DIR_TAB[r].tag, DIR_TAB[r].typed, row_res);
    end
    drain_results();

    // random: drifting enqueue bias walks the queue between empty and full
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 31; rx_idle_pct = 59; end
        1: begin tx_idle_pct = 59; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int k = 0; k < N_PHASE; k++) begin
        if (k % 48 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 20;
            1: enq_pct = 50;
            default: enq_pct = 80;
          endcase
        end
        if (ph == 0 && k == N_PHASE / 2) drain_results();
        act = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ;
        // narrow priorities make ties common
        pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
        tag = 16'($urandom_range(0, 65535));
        send_op(act, pri, tag, 1'b0, '0);
      end
    end

    // wait for the last results, then a few idle cycles
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (8) @(posedge clk);
      if (pending_results.size() != 0) errors++;
      $display("Stored %0d entries and served %0d; rejected %0d full enqueues,",
               n_enq_ok, n_deq_ok, n_full);
      $display("%0d empty dequeues; peak fill %0d, with priority ties and stalls on both sides.",
               n_empty, max_fill);
      if (errors == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

endmodule
